### rtl/sgr_pkg.sv
// Shared types, codes and the SGR attribute update function for the tracker.
package sgr_pkg;

  typedef enum logic [2:0] {
    PH_IDLE, PH_UTF8, PH_ESC, PH_PARAM, PH_INTER, PH_TAIL
  } phase_t;

  typedef enum logic [1:0] {CC_NONE, CC_SELECT, CC_COLLECT} cc_stage_t;

  localparam logic [2:0] KIND_ASCII = 3'd0;
  localparam logic [2:0] KIND_UTF8  = 3'd1;
  localparam logic [2:0] KIND_SGR   = 3'd2;
  localparam logic [2:0] KIND_CSI   = 3'd3;
  localparam logic [2:0] KIND_ESC   = 3'd4;
  localparam logic [2:0] KIND_C0    = 3'd5;
  localparam logic [2:0] KIND_NL    = 3'd6;

  localparam logic [3:0] W_OK      = 4'd0;
  localparam logic [3:0] W_UNKNOWN = 4'd1;
  localparam logic [3:0] W_NONSTD  = 4'd2;
  localparam logic [3:0] W_UNSUPP  = 4'd3;
  localparam logic [3:0] W_NONSGR  = 4'd4;
  localparam logic [3:0] W_MALF    = 4'd5;
  localparam logic [3:0] W_ESC     = 4'd6;
  localparam logic [3:0] W_BADESC  = 4'd7;
  localparam logic [3:0] W_C0      = 4'd8;
  localparam logic [3:0] W_UTF8    = 4'd9;

  localparam logic REG_CAPS = 1'b0;
  localparam logic REG_ZW   = 1'b1;

  typedef struct packed {
    logic [12:0] style;
    logic [7:0]  fg;
    logic [25:0] fgx;
    logic [7:0]  bg;
    logic [25:0] bgx;
    logic [3:0]  border;
    logic [4:0]  ideo;
    logic [4:0]  font;
  } attrs_t;

  typedef struct packed {
    cc_stage_t  stage;
    logic       is_bg;
    logic       is_rgb;
    logic [1:0] count;
    logic [23:0] acc;
  } collect_t;

  typedef struct packed {
    logic       valid;
    logic [2:0] kind;
    logic       width;
    logic [3:0] warn;
  } result_t;

  localparam attrs_t ATTRS_RESET = '{style: '0, fg: 8'hFF, fgx: '0, bg: 8'hFF,
                                     bgx: '0, border: '0, ideo: '0, font: '0};

  typedef struct packed {
    attrs_t    a;
    logic      unknown;
    logic      start_ext;
    logic      ext_bg;
  } sgr_res_t;

  function automatic sgr_res_t apply_sgr(attrs_t a_in, logic [7:0] v, logic bright);
    sgr_res_t r;
    r = '{a: a_in, unknown: 1'b0, start_ext: 1'b0, ext_bg: 1'b0};
    if (v == 8'd0) r.a = ATTRS_RESET;
    else if (v < 8'd10) r.a.style[v[3:0]] = 1'b1;
    else if (v < 8'd20) r.a.font = (v == 8'd10) ? 5'd0 : v[4:0];
    else if (v == 8'd20) r.a.style[10] = 1'b1;
    else if (v == 8'd21) r.a.style[11] = 1'b1;
    else if (v == 8'd22) begin r.a.style[1] = 1'b0; r.a.style[2] = 1'b0; end
    else if (v == 8'd23) begin r.a.style[3] = 1'b0; r.a.style[10] = 1'b0; end
    else if (v == 8'd24) begin r.a.style[4] = 1'b0; r.a.style[11] = 1'b0; end
    else if (v == 8'd25) begin r.a.style[5] = 1'b0; r.a.style[6] = 1'b0; end
    else if (v == 8'd26) r.a.style[12] = 1'b1;
    else if (v < 8'd30) r.a.style[4'(v - 8'd20)] = 1'b0;
    else if (v < 8'd50) begin
      logic       isbg;
      logic [7:0] code;
      isbg = (v >= 8'd40);
      code = v - (isbg ? 8'd40 : 8'd30);
      if (code == 8'd8) begin
        r.start_ext = 1'b1;
        r.ext_bg = isbg;
      end else begin
        if (code == 8'd9) code = 8'hFF;
        if (isbg) r.a.bg = code; else r.a.fg = code;
      end
    end else if ((v >= 8'd90 && v <= 8'd97) || (v >= 8'd100 && v <= 8'd107)) begin
      if (bright) begin
        if (v < 8'd100) r.a.fg = v; else r.a.bg = v;
      end
    end else if (v == 8'd50) r.a.style[12] = 1'b0;
    else if (v < 8'd54) r.a.border[2'(v - 8'd50)] = 1'b1;
    else if (v == 8'd54) begin r.a.border[1] = 1'b0; r.a.border[2] = 1'b0; end
    else if (v == 8'd55) r.a.border[3] = 1'b0;
    else if (v >= 8'd60 && v < 8'd65) r.a.ideo[3'(v - 8'd60)] = 1'b1;
    else if (v == 8'd65) r.a.ideo = '0;
    else r.unknown = 1'b1;
    return r;
  endfunction

  function automatic logic [3:0] wmax(logic [3:0] a, logic [3:0] b);
    return (a > b) ? a : b;
  endfunction

endpackage

### rtl/sgr_core.sv
// Parser state and the per-byte decode into attributes and a result.
module sgr_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic [7:0]           data_byte,
  input  logic [2:0]           caps,
  input  logic [1:0]           zw,
  output sgr_pkg::result_t     res,
  output sgr_pkg::attrs_t      live
);
  import sgr_pkg::*;

  phase_t     phase, phase_next;
  logic [9:0] tok, tok_next;
  logic [2:0] dcnt, dcnt_next;
  logic [3:0] flags, flags_next;
  attrs_t     saved, saved_next, live_next;
  collect_t   cc, cc_next;
  logic [3:0] worst, worst_next;
  logic [1:0] urem, urem_next;

  function automatic result_t mk(logic [2:0] k, logic w, logic [3:0] wr);
    return '{valid: 1'b1, kind: k, width: w, warn: wr};
  endfunction

  always_comb begin
    logic [7:0] b;
    logic [7:0] lo, hi;
    logic       err_nz;
    logic [3:0] err;
    logic [7:0] v;
    logic       last;
    logic       is_sgr_end, is_csi_end;
    logic [1:0] cnt;
    logic       idle_go;
    sgr_res_t   s;
    b = data_byte;
    phase_next = phase; tok_next = tok; dcnt_next = dcnt; flags_next = flags;
    saved_next = saved; live_next = live; cc_next = cc; worst_next = worst;
    urem_next = urem;
    res = '0;
    lo = 8'h80; hi = 8'hBF;
    err = W_OK; v = 8'd0; last = 1'b0; err_nz = 1'b0;
    is_sgr_end = 1'b0; is_csi_end = 1'b0; cnt = flags[2:1]; idle_go = 1'b0;
    s = '0;

    unique case (phase)
      PH_UTF8: begin
        if (tok[7:0] == 8'hE0) lo = 8'hA0;
        else if (tok[7:0] == 8'hED) hi = 8'h9F;
        else if (tok[7:0] == 8'hF0) lo = 8'h90;
        else if (tok[7:0] == 8'hF4) hi = 8'h8F;
        if (b >= lo && b <= hi) begin
          tok_next = '0;
          if (urem <= 2'd1) begin
            urem_next = 2'd0;
            phase_next = PH_IDLE;
            res = mk(KIND_UTF8, 1'b1, W_OK);
          end else urem_next = urem - 2'd1;
        end else begin
          phase_next = PH_IDLE; urem_next = '0; tok_next = '0;
          idle_go = 1'b1;
        end
      end
      PH_ESC: begin
        if (b == 8'h5B) begin
          phase_next = PH_PARAM; tok_next = '0; dcnt_next = '0; flags_next = '0;
        end else if (b == 8'h1B) begin
          res = mk(KIND_ESC, 1'b0, wmax(worst, W_BADESC));
          saved_next = live; worst_next = W_OK;
        end else begin
          worst_next = wmax(worst, (b >= 8'h40 && b <= 8'h7E) ? W_ESC : W_BADESC);
          phase_next = PH_IDLE;
          res = mk(KIND_ESC, 1'b0, worst_next);
        end
      end
      PH_PARAM: begin
        if (b == 8'h3B || b == 8'h6D) begin
          last = (b == 8'h6D);
          v = tok[7:0];
          if (flags[0]) begin err = W_NONSTD; v = 8'd0; end
          else if (dcnt > 3'd3 || tok > 10'd255) err = W_UNKNOWN;
          err_nz = (err != W_OK);
          tok_next = '0; dcnt_next = '0; flags_next = '0;
          worst_next = wmax(worst, err);
          s = apply_sgr(live, v, caps[0]);
          unique case (cc.stage)
            CC_SELECT: begin
              cc_next.stage = CC_NONE;
              if (!err_nz) begin
                if (v == 8'd2 || v == 8'd5) begin
                  if (last) worst_next = wmax(worst_next, W_UNKNOWN);
                  else if (!((v == 8'd2) ? caps[2] : caps[1])) begin
                    worst_next = wmax(worst_next, W_UNSUPP);
                    live_next = s.a;
                    if (s.unknown) worst_next = wmax(worst_next, W_UNKNOWN);
                  end else begin
                    cc_next.stage = CC_COLLECT; cc_next.is_rgb = (v == 8'd2);
                    cc_next.count = '0; cc_next.acc = '0;
                  end
                end else begin
                  worst_next = wmax(worst_next, W_UNKNOWN);
                  live_next = s.a;
                  if (s.start_ext) begin
                    cc_next.stage = CC_SELECT; cc_next.is_bg = s.ext_bg;
                  end
                end
              end
            end
            CC_COLLECT: begin
              if (err_nz) cc_next.stage = CC_NONE;
              else begin
                cc_next.acc = {cc.acc[15:0], v};
                cc_next.count = cc.count + 2'd1;
                if (cc_next.count >= (cc.is_rgb ? 2'd3 : 2'd1)) begin
                  if (cc.is_bg) begin
                    live_next.bg = 8'd8;
                    live_next.bgx = {cc.is_rgb ? 2'd2 : 2'd1, cc_next.acc};
                  end else begin
                    live_next.fg = 8'd8;
                    live_next.fgx = {cc.is_rgb ? 2'd2 : 2'd1, cc_next.acc};
                  end
                  cc_next.stage = CC_NONE;
                end else if (last) begin
                  worst_next = wmax(worst_next, W_UNKNOWN);
                  cc_next.stage = CC_NONE;
                end
              end
            end
            default: begin
              if (!err_nz) begin
                live_next = s.a;
                if (s.unknown) worst_next = wmax(worst_next, W_UNKNOWN);
                if (s.start_ext) begin
                  cc_next.stage = CC_SELECT; cc_next.is_bg = s.ext_bg;
                end
              end
            end
          endcase
          is_sgr_end = last;
        end else if (b >= 8'h30 && b <= 8'h3F) begin
          if (b > 8'h39) flags_next[0] = 1'b1;
          else if (b != 8'h30 || dcnt != 3'd0) begin
            if (dcnt < 3'd3)
              tok_next = 10'(tok * 10'd10 + 10'(b - 8'h30));
            if (dcnt < 3'd4) dcnt_next = dcnt + 3'd1;
          end
        end else if (b >= 8'h20 && b <= 8'h2F) begin
          flags_next = {flags[3], 2'b01, flags[0]};
          phase_next = PH_INTER;
        end else begin
          worst_next = wmax(worst, (b >= 8'h40 && b <= 8'h7E) ? W_NONSGR : W_MALF);
          is_csi_end = 1'b1;
        end
      end
      PH_INTER: begin
        if (b >= 8'h20 && b <= 8'h2F) begin
          if (cnt < 2'd2) cnt = cnt + 2'd1;
          flags_next = {flags[3], cnt, flags[0]};
        end else if (b >= 8'h30 && b <= 8'h3F) phase_next = PH_TAIL;
        else begin
          worst_next = wmax(worst, (b >= 8'h40 && b <= 8'h7E && cnt <= 2'd1) ?
                                   W_NONSGR : W_MALF);
          is_csi_end = 1'b1;
        end
      end
      PH_TAIL: begin
        if (!(b >= 8'h20 && b <= 8'h3F)) begin
          worst_next = wmax(worst, W_MALF);
          is_csi_end = 1'b1;
        end
      end
      default: begin
        phase_next = PH_IDLE;
        idle_go = 1'b1;
      end
    endcase

    // Sequence end: a pending extended colour is dropped in either case.
    if (is_sgr_end || is_csi_end) begin
      if (cc_next.stage != CC_NONE) begin
        if (is_sgr_end) worst_next = wmax(worst_next, W_UNKNOWN);
        cc_next.stage = CC_NONE;
      end
      if (is_csi_end) live_next = saved;
      phase_next = PH_IDLE;
      tok_next = '0; dcnt_next = '0; flags_next = '0;
      res = mk(is_sgr_end ? KIND_SGR : KIND_CSI, 1'b0, worst_next);
    end

    if (idle_go) begin
      if (b == 8'h00) res = '0;
      else if (b >= 8'h20 && b <= 8'h7E) res = mk(KIND_ASCII, 1'b1, W_OK);
      else if (b == 8'h1B) begin
        saved_next = live; worst_next = W_OK; cc_next.stage = CC_NONE;
        tok_next = '0; dcnt_next = '0; flags_next = '0;
        phase_next = PH_ESC;
      end else if (b == 8'h0A) res = mk(KIND_NL, !zw[1], W_OK);
      else if (b < 8'h20 || b == 8'h7F) res = mk(KIND_C0, !zw[0], W_C0);
      else if (b >= 8'hC2 && b <= 8'hF4) begin
        urem_next = (b < 8'hE0) ? 2'd1 : (b < 8'hF0) ? 2'd2 : 2'd3;
        tok_next = {2'b00, b};
        phase_next = PH_UTF8;
      end else res = mk(KIND_UTF8, 1'b1, W_UTF8);
      // A byte that broke a started character.
      if (phase == PH_UTF8) begin
        if (res.valid) res.warn = W_UTF8;
        else res = mk(KIND_UTF8, 1'b1, W_UTF8);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE; tok <= '0; dcnt <= '0; flags <= '0;
      live <= ATTRS_RESET; saved <= ATTRS_RESET; cc <= '0;
      worst <= '0; urem <= '0;
    end else if (step) begin
      phase <= phase_next; tok <= tok_next; dcnt <= dcnt_next; flags <= flags_next;
      live <= live_next; saved <= saved_next; cc <= cc_next;
      worst <= worst_next; urem <= urem_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (phase == PH_UTF8) |-> (urem != 2'd0))
    else $error("utf8 phase with nothing remaining");
  assert property (@(posedge clk) disable iff (rst)
    (phase == PH_IDLE) |-> (cc.stage == CC_NONE))
    else $error("colour collection outside a sequence");
  assert property (@(posedge clk) disable iff (rst)
    (step && res.valid && res.kind == KIND_CSI) |=> (live == $past(saved)))
    else $error("non-SGR sequence did not restore attributes");
endmodule

### rtl/ansi_sgr_attribute_tracker.sv
// Top level of the SGR attribute tracker: config registers, core and output register.
// Usage: text bytes enter on data_byte with in_valid/in_stall; results leave
// on the attribute ports with out_valid/out_stall. A transaction happens at a
// rising edge with valid high and stall low.
// Each byte is decoded combinationally by the core; a result, when the byte
// causes one, is registered and shown in the cycle after acceptance.
// Throughput is one byte per cycle, set by the single result register: a new
// byte is accepted while the register is empty or is being emptied.
// When the receiver stalls with a result held, in_stall rises and the byte
// stream waits; bytes that cause no result still pass only when the result
// register can take one, which keeps ordering simple.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect next cycle.
// Reset (rst, synchronous) clears the parser, sets default attributes and
// loads terminal_caps = 7 and zero_width_controls = 3.
module ansi_sgr_attribute_tracker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         data_byte,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [2:0]         cfg_data,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         item_kind,
  output logic               width_increment,
  output logic [12:0]        style_bits,
  output logic signed [7:0]  fg_code,
  output logic [25:0]        fg_extended,
  output logic signed [7:0]  bg_code,
  output logic [25:0]        bg_extended,
  output logic [3:0]         border_bits,
  output logic [4:0]         ideogram_bits,
  output logic [4:0]         font_sel,
  output logic [3:0]         warn_code
);
  import sgr_pkg::*;

  logic [2:0] caps;
  logic [1:0] zw;
  logic       step;
  result_t    res;
  attrs_t     live;

  assign in_stall = out_valid && out_stall;
  assign step = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      caps <= 3'd7;
      zw <= 2'd3;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CAPS: caps <= cfg_data;
        REG_ZW:   zw <= cfg_data[1:0];
        default:  ;
      endcase
    end
  end

  sgr_core u_core (
    .clk(clk), .rst(rst), .step(step), .data_byte(data_byte),
    .caps(caps), .zw(zw), .res(res), .live(live)
  );

  // Live attributes come registered from the core with the post-step values.
  logic [2:0] kind_r;
  logic       width_r;
  logic [3:0] warn_r;

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (!in_stall) out_valid <= step && res.valid;
  end

  always_ff @(posedge clk) begin
    if (step && res.valid) begin
      kind_r <= res.kind; width_r <= res.width; warn_r <= res.warn;
    end
  end

  assign item_kind = kind_r;
  assign width_increment = width_r;
  assign warn_code = warn_r;
  assign style_bits = live.style;
  assign fg_code = live.fg;
  assign fg_extended = live.fgx;
  assign bg_code = live.bg;
  assign bg_extended = live.bgx;
  assign border_bits = live.border;
  assign ideogram_bits = live.ideo;
  assign font_sel = live.font;

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> $stable(live))
    else $error("attributes changed under a stalled result");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && (item_kind == KIND_SGR || item_kind == KIND_CSI ||
     item_kind == KIND_ESC)) |-> !width_increment)
    else $error("escape sequence took a column");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && item_kind == KIND_ASCII) |-> width_increment)
    else $error("ascii character took no column");
endmodule

### bench/tb_ansi_sgr_attribute_tracker.sv
// Self-checking testbench for the ANSI SGR attribute tracker, with a built-in predictor.
module tb_ansi_sgr_attribute_tracker;
  import sgr_pkg::*;

  typedef struct packed {
    logic [2:0] kind;
    logic       wide;
    attrs_t     a;
    logic [3:0] warn;
  } char_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        cfg_we = 1'b0;
  logic        cfg_index = REG_CAPS;
  logic [2:0]  cfg_data = 3'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  item_kind;
  logic        width_increment;
  logic [12:0] style_bits;
  logic signed [7:0] fg_code, bg_code;
  logic [25:0] fg_extended, bg_extended;
  logic [3:0]  border_bits;
  logic [4:0]  ideogram_bits, font_sel;
  logic [3:0]  warn_code;

  ansi_sgr_attribute_tracker u_dut (.*);

  always #4 clk = ~clk;

  logic [7:0]   byte_queue[$];
  char_result_t expected_chars[$];
  int           mismatches = 0;
  bit           byte_taken = 1'b0;
  bit           calm = 1'b0;
  int           in_gap = 0, out_gap = 0;

  // Predictor state.
  logic [2:0] caps_reg = 3'd7;
  logic [1:0] zw_reg = 2'd3;
  phase_t     ph = PH_IDLE;
  int         tok, digits, inter;
  bit         nonstd;
  attrs_t     live, saved;
  cc_stage_t  cc_stage = CC_NONE;
  bit         cc_bg, cc_rgb;
  int         cc_cnt, cc_acc, worst, utf_left;

  task automatic expect_char(int kind, int wide, int warn);
    char_result_t r;
    r.kind = kind[2:0];
    r.wide = wide[0];
    r.a = live;
    r.warn = warn[3:0];
    expected_chars.push_back(r);
  endtask

  function automatic void raise(int w);
    if (w > worst) worst = w;
  endfunction

  function automatic void clear_tok();
    tok = 0; digits = 0; nonstd = 1'b0; inter = 0;
  endfunction

  function automatic void sgr_update(int v);
    int code;
    bit bgc;
    if (v == 0) live = ATTRS_RESET;
    else if (v < 10) live.style[v] = 1'b1;
    else if (v < 20) live.font = (v == 10) ? 5'd0 : v[4:0];
    else if (v == 20) live.style[10] = 1'b1;
    else if (v == 21) live.style[11] = 1'b1;
    else if (v == 22) begin live.style[1] = 1'b0; live.style[2] = 1'b0; end
    else if (v == 23) begin live.style[3] = 1'b0; live.style[10] = 1'b0; end
    else if (v == 24) begin live.style[4] = 1'b0; live.style[11] = 1'b0; end
    else if (v == 25) begin live.style[5] = 1'b0; live.style[6] = 1'b0; end
    else if (v == 26) live.style[12] = 1'b1;
    else if (v < 30) live.style[v - 20] = 1'b0;
    else if (v < 50) begin
      bgc = (v >= 40);
      code = v - (bgc ? 40 : 30);
      if (code == 8) begin
        cc_stage = CC_SELECT;
        cc_bg = bgc;
      end else begin
        if (code == 9) code = -1;
        if (bgc) live.bg = code[7:0]; else live.fg = code[7:0];
      end
    end else if ((v >= 90 && v <= 97) || (v >= 100 && v <= 107)) begin
      if (caps_reg[0]) begin
        if (v < 100) live.fg = v[7:0]; else live.bg = v[7:0];
      end
    end else if (v == 50) live.style[12] = 1'b0;
    else if (v < 54) live.border[v - 50] = 1'b1;
    else if (v == 54) begin live.border[1] = 1'b0; live.border[2] = 1'b0; end
    else if (v == 55) live.border[3] = 1'b0;
    else if (v >= 60 && v < 65) live.ideo[v - 60] = 1'b1;
    else if (v == 65) live.ideo = '0;
    else raise(W_UNKNOWN);
  endfunction

  function automatic void take_param(int err, int v, bit last);
    logic [25:0] x;
    raise(err);
    if (cc_stage == CC_SELECT) begin
      cc_stage = CC_NONE;
      if (err != 0) return;
      if (v == 2 || v == 5) begin
        if (last) begin raise(W_UNKNOWN); return; end
        if (!caps_reg[(v == 2) ? 2 : 1]) begin raise(W_UNSUPP); sgr_update(v); return; end
        cc_stage = CC_COLLECT; cc_rgb = (v == 2); cc_cnt = 0; cc_acc = 0;
        return;
      end
      raise(W_UNKNOWN);
      sgr_update(v);
    end else if (cc_stage == CC_COLLECT) begin
      if (err != 0) begin cc_stage = CC_NONE; return; end
      cc_acc = ((cc_acc << 8) | (v & 255)) & 24'hFFFFFF;
      cc_cnt++;
      if (cc_cnt >= (cc_rgb ? 3 : 1)) begin
        x = {(cc_rgb ? 2'd2 : 2'd1), cc_acc[23:0]};
        if (cc_bg) begin live.bg = 8'd8; live.bgx = x; end
        else begin live.fg = 8'd8; live.fgx = x; end
        cc_stage = CC_NONE;
      end else if (last) begin
        raise(W_UNKNOWN);
        cc_stage = CC_NONE;
      end
    end else if (err == 0) sgr_update(v);
  endfunction

  task automatic close_seq(bit is_sgr);
    if (cc_stage != CC_NONE) begin
      if (is_sgr) raise(W_UNKNOWN);
      cc_stage = CC_NONE;
    end
    if (!is_sgr) live = saved;
    ph = PH_IDLE;
    clear_tok();
    expect_char(is_sgr ? KIND_SGR : KIND_CSI, 0, worst);
  endtask

  // Decode outside any sequence; bad forces the warning to the UTF-8 one.
  task automatic idle_byte(int b, bit bad, output bit gave);
    gave = 1'b1;
    if (b == 0) gave = 1'b0;
    else if (b >= 8'h20 && b <= 8'h7E) expect_char(KIND_ASCII, 1, bad ? W_UTF8 : W_OK);
    else if (b == 8'h1B) begin
      saved = live; worst = 0; cc_stage = CC_NONE; clear_tok();
      ph = PH_ESC; gave = 1'b0;
    end else if (b == 8'h0A) expect_char(KIND_NL, !zw_reg[1], bad ? W_UTF8 : W_OK);
    else if (b < 8'h20 || b == 8'h7F) expect_char(KIND_C0, !zw_reg[0], bad ? W_UTF8 : W_C0);
    else if (b >= 8'hC2 && b <= 8'hF4) begin
      utf_left = (b < 8'hE0) ? 1 : (b < 8'hF0) ? 2 : 3;
      tok = b; ph = PH_UTF8; gave = 1'b0;
    end else expect_char(KIND_UTF8, 1, W_UTF8);
  endtask

  task automatic predict_byte(int b);
    int lo, hi, err, v;
    bit gave;
    case (ph)
      PH_UTF8: begin
        lo = 8'h80; hi = 8'hBF;
        if (tok == 8'hE0) lo = 8'hA0;
        else if (tok == 8'hED) hi = 8'h9F;
        else if (tok == 8'hF0) lo = 8'h90;
        else if (tok == 8'hF4) hi = 8'h8F;
        if (b >= lo && b <= hi) begin
          tok = 0;
          if (utf_left > 0) utf_left--;
          if (utf_left == 0) begin ph = PH_IDLE; expect_char(KIND_UTF8, 1, W_OK); end
        end else begin
          ph = PH_IDLE; utf_left = 0; tok = 0;
          idle_byte(b, 1'b1, gave);
          if (!gave) expect_char(KIND_UTF8, 1, W_UTF8);
        end
      end
      PH_ESC: begin
        if (b == 8'h5B) begin ph = PH_PARAM; clear_tok(); end
        else if (b == 8'h1B) begin
          raise(W_BADESC);
          expect_char(KIND_ESC, 0, worst);
          saved = live; worst = 0;
        end else begin
          raise((b >= 8'h40 && b <= 8'h7E) ? W_ESC : W_BADESC);
          ph = PH_IDLE;
          expect_char(KIND_ESC, 0, worst);
        end
      end
      PH_PARAM: begin
        if (b == 8'h3B || b == 8'h6D) begin
          err = 0; v = tok;
          if (nonstd) begin err = W_NONSTD; v = 0; end
          else if (digits > 3 || v > 255) err = W_UNKNOWN;
          clear_tok();
          take_param(err, v, b == 8'h6D);
          if (b == 8'h6D) close_seq(1'b1);
        end else if (b >= 8'h30 && b <= 8'h3F) begin
          if (b > 8'h39) nonstd = 1'b1;
          else if (b != 8'h30 || digits != 0) begin
            if (digits < 3) tok = tok * 10 + (b - 8'h30);
            if (digits < 4) digits++;
          end
        end else if (b >= 8'h20 && b <= 8'h2F) begin
          inter = 1; ph = PH_INTER;
        end else begin
          raise((b >= 8'h40 && b <= 8'h7E) ? W_NONSGR : W_MALF);
          close_seq(1'b0);
        end
      end
      PH_INTER: begin
        if (b >= 8'h20 && b <= 8'h2F) begin
          if (inter < 2) inter++;
        end else if (b >= 8'h30 && b <= 8'h3F) ph = PH_TAIL;
        else begin
          raise((b >= 8'h40 && b <= 8'h7E && inter <= 1) ? W_NONSGR : W_MALF);
          close_seq(1'b0);
        end
      end
      PH_TAIL: begin
        if (!(b >= 8'h20 && b <= 8'h3F)) begin
          raise(W_MALF);
          close_seq(1'b0);
        end
      end
      default: begin
        ph = PH_IDLE;
        idle_byte(b, 1'b0, gave);
      end
    endcase
  endtask

  // Monitor: checks results, then feeds accepted bytes to the predictor.
  always @(posedge clk) begin
    char_result_t got, want;
    byte_taken = !rst && in_valid && !in_stall;
    if (!rst && out_valid && !out_stall) begin
      got = '{kind: item_kind, wide: width_increment,
              a: '{style: style_bits, fg: fg_code, fgx: fg_extended, bg: bg_code,
                   bgx: bg_extended, border: border_bits, ideo: ideogram_bits,
                   font: font_sel},
              warn: warn_code};
      if (expected_chars.size() == 0) begin
        if (mismatches < 10) $display("Unexpected transaction: %h", got);
        mismatches++;
      end else begin
        want = expected_chars.pop_front();
        if (got !== want) begin
          if (mismatches < 10)
            $display({"Mismatch kind %0d/%0d width %0d/%0d style %h/%h fg %0d/%0d ",
                      "fgx %h/%h bg %0d/%0d bgx %h/%h border %h/%h ideo %h/%h ",
                      "font %0d/%0d warn %0d/%0d (expected/actual)"},
                     want.kind, got.kind, want.wide, got.wide, want.a.style, got.a.style,
                     $signed(want.a.fg), $signed(got.a.fg), want.a.fgx, got.a.fgx,
                     $signed(want.a.bg), $signed(got.a.bg), want.a.bgx, got.a.bgx,
                     want.a.border, got.a.border, want.a.ideo, got.a.ideo,
                     want.a.font, got.a.font, want.warn, got.warn);
          mismatches++;
        end
      end
    end
    if (byte_taken) predict_byte(data_byte);
  end

  // Driver: a new byte is offered only once the previous one has gone.
  always @(negedge clk) begin
    if (rst) in_valid <= 1'b0;
    else if (!in_valid || byte_taken) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (byte_queue.size() > 0) begin
        in_valid <= 1'b1;
        data_byte <= byte_queue.pop_front();
        if (!calm && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 8);
      end else in_valid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    if (out_gap > 0) begin
      out_gap--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if (!calm && $urandom_range(0, 6) == 0) out_gap = $urandom_range(1, 8);
    end
  end

  task automatic put(int b);
    byte_queue.push_back(b[7:0]);
  endtask

  task automatic put_text(string s);
    for (int i = 0; i < s.len(); i++) put(s[i]);
  endtask

  task automatic csi(string body);
    put(8'h1B);
    put(8'h5B);
    put_text(body);
  endtask

  task automatic put_num(int v);
    int z;
    z = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0;
    repeat (z) put(8'h30);
    put_text($sformatf("%0d", v));
  endtask

  task automatic put_param();
    int k;
    k = $urandom_range(0, 11);
    case (k)
      0: put_num($urandom_range(0, 9));
      1: put_num($urandom_range(10, 29));
      2: put_num($urandom_range(30, 49));
      3: begin
        put_num($urandom_range(0, 1) ? 38 : 48); put(8'h3B); put_num(5); put(8'h3B);
        put_num($urandom_range(0, 255));
      end
      4: begin
        put_num($urandom_range(0, 1) ? 38 : 48); put(8'h3B); put_num(2);
        repeat (3) begin put(8'h3B); put_num($urandom_range(0, 255)); end
      end
      5: put_num($urandom_range(90, 107));
      6: put_num($urandom_range(50, 65));
      7: put_num($urandom_range(0, 1100));
      8: begin put($urandom_range(8'h3A, 8'h3F)); put_num($urandom_range(0, 9)); end
      9: ;
      10: begin
        put_num($urandom_range(0, 1) ? 38 : 48);
        if ($urandom_range(0, 1)) begin put(8'h3B); put_num($urandom_range(0, 9)); end
      end
      default: begin
        put_num($urandom_range(0, 1) ? 38 : 48); put(8'h3B); put_num(2);
        repeat ($urandom_range(0, 2)) begin put(8'h3B); put_num($urandom_range(0, 300)); end
      end
    endcase
  endtask

  task automatic put_params();
    int n;
    n = $urandom_range(1, 4);
    for (int i = 0; i < n; i++) begin
      if (i > 0) put(8'h3B);
      put_param();
    end
  endtask

  task automatic random_item();
    int r, f, n;
    r = $urandom_range(0, 99);
    if (r < 22) put($urandom_range(8'h20, 8'h7E));
    else if (r < 32) begin
      n = $urandom_range(2, 4);
      f = (n == 2) ? $urandom_range(8'hC2, 8'hDF) :
          (n == 3) ? $urandom_range(8'hE0, 8'hEF) : $urandom_range(8'hF0, 8'hF4);
      put(f);
      if (f == 8'hE0) put($urandom_range(8'hA0, 8'hBF));
      else if (f == 8'hED) put($urandom_range(8'h80, 8'h9F));
      else if (f == 8'hF0) put($urandom_range(8'h90, 8'hBF));
      else if (f == 8'hF4) put($urandom_range(8'h80, 8'h8F));
      else put($urandom_range(8'h80, 8'hBF));
      repeat (n - 2) put($urandom_range(8'h80, 8'hBF));
    end else if (r < 37) begin
      put($urandom_range(8'hC2, 8'hF4));
      put($urandom_range(0, 255));
    end else if (r < 44) begin
      f = $urandom_range(0, 3);
      put(f == 0 ? 8'h0A : f == 1 ? 8'h7F : $urandom_range(0, 8'h1F));
    end else if (r < 72) begin
      put(8'h1B); put(8'h5B); put_params(); put(8'h6D);
    end else if (r < 82) begin
      put(8'h1B); put(8'h5B);
      if ($urandom_range(0, 1)) put_params();
      f = $urandom_range(0, 5);
      if (f == 1) put($urandom_range(8'h20, 8'h2F));
      if (f == 2) repeat (2) put($urandom_range(8'h20, 8'h2F));
      if (f == 3) begin
        put($urandom_range(8'h20, 8'h2F));
        repeat ($urandom_range(1, 3)) put($urandom_range(8'h20, 8'h3F));
      end
      if (f == 4) put($urandom_range(0, 1) ? $urandom_range(0, 8'h1F) :
                      $urandom_range(8'h7F, 8'hFF));
      else begin
        do f = $urandom_range(8'h40, 8'h7E); while (f == 8'h6D);
        put(f);
      end
    end else if (r < 88) begin
      put(8'h1B);
      put($urandom_range(0, 3) == 0 ? $urandom_range(0, 255) : $urandom_range(8'h40, 8'h5A));
    end else repeat ($urandom_range(1, 4)) put($urandom_range(0, 255));
  endtask

  task automatic write_reg(logic idx, logic [2:0] val);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_CAPS) caps_reg = val; else zw_reg = val[1:0];
  endtask

  // Waits until all bytes are in and every result has come, plus a short pause.
  task automatic drain();
    do @(negedge clk); while (byte_queue.size() != 0 || in_valid || expected_chars.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    logic [2:0] caps_set[6] = '{3'd7, 3'd0, 3'd1, 3'd2, 3'd4, 3'd7};
    logic [1:0] zw_set[6]   = '{2'd3, 2'd0, 2'd2, 2'd1, 2'd0, 2'd3};
    live = ATTRS_RESET; saved = ATTRS_RESET;
    clear_tok(); worst = 0; utf_left = 0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    for (int p = 0; p < 6; p++) begin
      write_reg(REG_CAPS, caps_set[p]);
      write_reg(REG_ZW, {1'b0, zw_set[p]});
      if (p == 0) begin
        put_text("A~ "); put(8'h00); put(8'h7F); put(8'h0A); put(8'h01);
        put(8'hC3); put(8'hA9); put(8'hE0); put(8'hA0); put(8'h80);
        put(8'hF4); put(8'h8F); put(8'hBF); put(8'hBF); put(8'h80); put(8'hFF);
        put(8'hC3); put_text("x"); put(8'hE2); put(8'h1B); put_text("[1;3;38;5;200m");
        put(8'h1B); put_text("c"); put(8'h1B); put(8'h01); put(8'h1B); put(8'h1B);
        put_text("c");
        csi("48;2;1;2;3;4;21;53;61m");
        csi("0001;0256;1234;999m");
        csi("?1;7m"); csi("38m"); csi("38;2;1m"); csi("38;7m"); csi("4;2J");
        csi("1!!x"); csi("1!1;;;x"); csi("1;3"); put(8'h00);
        put(8'h1B); put(8'h00); csi("9;"); put(8'h80); put_text("z");
      end
      if (p == 5) calm = 1'b1;
      for (int i = 0; i < 20; i++) random_item();
      drain();
    end
    repeat (10) @(negedge clk);
    if (mismatches == 0 && expected_chars.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  initial begin
    #8000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

### ansi_sgr_attribute_tracker.f
rtl/sgr_pkg.sv
rtl/sgr_core.sv
rtl/ansi_sgr_attribute_tracker.sv
bench/tb_ansi_sgr_attribute_tracker.sv
